/* rtl/hsl_pkg.sv */
// Shared types, widths and constants for the HSL to RGB converter.
`default_nettype none

package hsl_pkg;

  localparam int unsigned FRAC_BITS = 12;
  localparam int unsigned ONE       = 1 << FRAC_BITS;

  localparam int unsigned HUE_W = FRAC_BITS;
  localparam int unsigned SAT_W = FRAC_BITS + 1;
  localparam int unsigned MUL_W = FRAC_BITS + 2;
  localparam int unsigned QP_W  = 2 * FRAC_BITS + 1;
  localparam int unsigned T_W   = FRAC_BITS + 2;
  localparam int unsigned W_W   = FRAC_BITS + 1;
  localparam int unsigned V_W   = 3 * FRAC_BITS + 1;
  localparam int unsigned CH_W  = 8;
  localparam int unsigned PK_W  = 4 * CH_W;

  localparam logic [CH_W-1:0] ALPHA  = 8'hFF;
  localparam logic [CH_W-1:0] CH_MAX = 8'hFF;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] saturation;
    logic [SAT_W-1:0] lightness;
  } hsl_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [PK_W-1:0] packed_color;
  } rgb_t;

  typedef struct packed {
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } hsl_adv_t;

endpackage

`default_nettype wire

/* rtl/hsl_ch_ramp.sv */
// One color channel: hue ramp, scale by 255 and clamp, four pipeline stages.
`default_nettype none

module hsl_ch_ramp (
  input  wire logic                         clk,
  input  wire hsl_pkg::hsl_adv_t            adv,
  input  wire logic [hsl_pkg::QP_W-1:0]     q,
  input  wire logic [hsl_pkg::QP_W-1:0]     p,
  input  wire logic [hsl_pkg::T_W-1:0]      t,
  output logic      [hsl_pkg::CH_W-1:0]     chan
);

  logic [hsl_pkg::QP_W-1:0] diff_next;
  logic [hsl_pkg::QP_W-1:0] base_next;
  logic [hsl_pkg::W_W-1:0]  wgt_next;
  logic [hsl_pkg::T_W-1:0]  fall_m;

  logic [hsl_pkg::QP_W-1:0] diff3;
  logic [hsl_pkg::QP_W-1:0] base3;
  logic [hsl_pkg::W_W-1:0]  wgt3;

  logic [hsl_pkg::QP_W+hsl_pkg::W_W-1:0] prod_full;
  logic [hsl_pkg::V_W-1:0]  prod4;
  logic [hsl_pkg::QP_W-1:0] base4;

  logic [hsl_pkg::V_W-1:0]  val_next;
  logic [hsl_pkg::V_W-1:0]  val5;

  logic [hsl_pkg::V_W+7:0]  scaled;
  logic [hsl_pkg::V_W+7-3*hsl_pkg::FRAC_BITS:0] byte_raw;

  always_comb begin
    diff_next = q - p;
    fall_m    = hsl_pkg::T_W'(2 * hsl_pkg::ONE) - t;
    if (t < hsl_pkg::T_W'(hsl_pkg::ONE / 2)) begin
      base_next = p;
      wgt_next  = hsl_pkg::W_W'({t, 1'b0});
    end else if (t < hsl_pkg::T_W'(3 * hsl_pkg::ONE / 2)) begin
      base_next = q;
      wgt_next  = '0;
    end else if (t < hsl_pkg::T_W'(2 * hsl_pkg::ONE)) begin
      base_next = p;
      wgt_next  = hsl_pkg::W_W'({fall_m, 1'b0});
    end else begin
      base_next = p;
      wgt_next  = '0;
    end
  end

  assign prod_full = diff3 * wgt3;
  assign val_next  = {base4, {hsl_pkg::FRAC_BITS{1'b0}}} + prod4;
  assign scaled    = {val5, 8'b0} - {8'b0, val5};
  assign byte_raw  = scaled[hsl_pkg::V_W+7:3*hsl_pkg::FRAC_BITS];

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      diff3 <= diff_next;
      base3 <= base_next;
      wgt3  <= wgt_next;
    end
    if (adv.s4) begin
      prod4 <= prod_full[hsl_pkg::V_W-1:0];
      base4 <= base3;
    end
    if (adv.s5) begin
      val5 <= val_next;
    end
    if (adv.s6) begin
      chan <= byte_raw[hsl_pkg::CH_W] ? hsl_pkg::CH_MAX : byte_raw[hsl_pkg::CH_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* rtl/hsl_to_rgb_color.sv */
// Top level of the pipelined HSL to RGB color converter.
//
//   channel  payload          valid       ready       direction
//   hsl      hsl_pkg::hsl_t   hsl_valid   hsl_ready   in
//   rgb      hsl_pkg::rgb_t   rgb_valid   rgb_ready   out
//
// Six register stages: one item accepted per cycle unless the output stalls.
// The depth is set by the q/p multiplier, the q/p adders, the ramp select,
// the ramp multiplier, the ramp add and the scale-by-255 subtract.
// Each stage loads when it is empty or the stage after it loads, so bubbles
// close up while the output waits. Reset clears the valid bits only.
`default_nettype none

module hsl_to_rgb_color (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire hsl_pkg::hsl_t hsl,
  input  wire logic          hsl_valid,
  output logic               hsl_ready,
  output hsl_pkg::rgb_t      rgb,
  output logic               rgb_valid,
  input  wire logic          rgb_ready
);

  logic [6:1] vld;
  logic [6:1] ld;
  hsl_pkg::hsl_adv_t adv;

  logic [hsl_pkg::HUE_W-1:0] h_in;
  logic [hsl_pkg::SAT_W-1:0] s_cl;
  logic [hsl_pkg::SAT_W-1:0] l_cl;
  logic                      lhi_next;
  logic [hsl_pkg::SAT_W-1:0] mul_a;
  logic [hsl_pkg::MUL_W-1:0] mul_b;
  logic [hsl_pkg::SAT_W+hsl_pkg::MUL_W-1:0] mul_full;
  logic [hsl_pkg::T_W-1:0]   tg_next;
  logic [hsl_pkg::T_W:0]     tr_sum;
  logic [hsl_pkg::T_W:0]     tb_sum;
  logic [hsl_pkg::T_W-1:0]   tr_next;
  logic [hsl_pkg::T_W-1:0]   tb_next;

  logic [hsl_pkg::QP_W-1:0]  mp1;
  logic [hsl_pkg::SAT_W-1:0] l1;
  logic                      lhi1;
  logic [hsl_pkg::T_W-1:0]   tr1;
  logic [hsl_pkg::T_W-1:0]   tg1;
  logic [hsl_pkg::T_W-1:0]   tb1;

  logic [hsl_pkg::QP_W-1:0]  q_next;
  logic [hsl_pkg::QP_W:0]    p_full;
  logic [hsl_pkg::QP_W-1:0]  q2;
  logic [hsl_pkg::QP_W-1:0]  p2;
  logic [hsl_pkg::T_W-1:0]   tr2;
  logic [hsl_pkg::T_W-1:0]   tg2;
  logic [hsl_pkg::T_W-1:0]   tb2;

  logic [hsl_pkg::CH_W-1:0]  red_ch;
  logic [hsl_pkg::CH_W-1:0]  green_ch;
  logic [hsl_pkg::CH_W-1:0]  blue_ch;

  assign ld[6] = !vld[6] || rgb_ready;
  assign ld[5] = !vld[5] || ld[6];
  assign ld[4] = !vld[4] || ld[5];
  assign ld[3] = !vld[3] || ld[4];
  assign ld[2] = !vld[2] || ld[3];
  assign ld[1] = !vld[1] || ld[2];
  assign hsl_ready = ld[1];
  assign rgb_valid = vld[6];

  assign adv.s3 = ld[3];
  assign adv.s4 = ld[4];
  assign adv.s5 = ld[5];
  assign adv.s6 = ld[6];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld[1]) vld[1] <= hsl_valid;
      if (ld[2]) vld[2] <= vld[1];
      if (ld[3]) vld[3] <= vld[2];
      if (ld[4]) vld[4] <= vld[3];
      if (ld[5]) vld[5] <= vld[4];
      if (ld[6]) vld[6] <= vld[5];
    end
  end

  always_comb begin
    h_in = hsl.hue;
    s_cl = (hsl.saturation > hsl_pkg::SAT_W'(hsl_pkg::ONE)) ?
           hsl_pkg::SAT_W'(hsl_pkg::ONE) : hsl.saturation;
    l_cl = (hsl.lightness > hsl_pkg::SAT_W'(hsl_pkg::ONE)) ?
           hsl_pkg::SAT_W'(hsl_pkg::ONE) : hsl.lightness;
    lhi_next = l_cl >= hsl_pkg::SAT_W'(hsl_pkg::ONE / 2);
    if (lhi_next) begin
      mul_a = s_cl;
      mul_b = hsl_pkg::MUL_W'(hsl_pkg::ONE) - hsl_pkg::MUL_W'(l_cl);
    end else begin
      mul_a = l_cl;
      mul_b = hsl_pkg::MUL_W'(hsl_pkg::ONE) + hsl_pkg::MUL_W'(s_cl);
    end
    mul_full = mul_a * mul_b;
    tg_next  = hsl_pkg::T_W'({h_in, 1'b0}) + hsl_pkg::T_W'(h_in);
    tr_sum   = (hsl_pkg::T_W+1)'(tg_next) + (hsl_pkg::T_W+1)'(hsl_pkg::ONE);
    tb_sum   = (hsl_pkg::T_W+1)'(tg_next) + (hsl_pkg::T_W+1)'(2 * hsl_pkg::ONE);
    tr_next  = (tr_sum >= (hsl_pkg::T_W+1)'(3 * hsl_pkg::ONE)) ?
               hsl_pkg::T_W'(tr_sum - (hsl_pkg::T_W+1)'(3 * hsl_pkg::ONE)) :
               hsl_pkg::T_W'(tr_sum);
    tb_next  = (tb_sum >= (hsl_pkg::T_W+1)'(3 * hsl_pkg::ONE)) ?
               hsl_pkg::T_W'(tb_sum - (hsl_pkg::T_W+1)'(3 * hsl_pkg::ONE)) :
               hsl_pkg::T_W'(tb_sum);
  end

  always_comb begin
    q_next = mp1 + (lhi1 ? {l1, {hsl_pkg::FRAC_BITS{1'b0}}} : '0);
    p_full = {l1, {(hsl_pkg::FRAC_BITS+1){1'b0}}} - (hsl_pkg::QP_W+1)'(q_next);
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      mp1  <= mul_full[hsl_pkg::QP_W-1:0];
      l1   <= l_cl;
      lhi1 <= lhi_next;
      tr1  <= tr_next;
      tg1  <= tg_next;
      tb1  <= tb_next;
    end
    if (ld[2]) begin
      q2  <= q_next;
      p2  <= p_full[hsl_pkg::QP_W-1:0];
      tr2 <= tr1;
      tg2 <= tg1;
      tb2 <= tb1;
    end
  end

  hsl_ch_ramp u_red (
    .clk  (clk),
    .adv  (adv),
    .q    (q2),
    .p    (p2),
    .t    (tr2),
    .chan (red_ch)
  );

  hsl_ch_ramp u_green (
    .clk  (clk),
    .adv  (adv),
    .q    (q2),
    .p    (p2),
    .t    (tg2),
    .chan (green_ch)
  );

  hsl_ch_ramp u_blue (
    .clk  (clk),
    .adv  (adv),
    .q    (q2),
    .p    (p2),
    .t    (tb2),
    .chan (blue_ch)
  );

  always_comb begin
    rgb.red          = red_ch;
    rgb.green        = green_ch;
    rgb.blue         = blue_ch;
    rgb.packed_color = {hsl_pkg::ALPHA, blue_ch, green_ch, red_ch};
  end

`ifndef SYNTHESIS
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    rgb_ready |-> hsl_ready)
    else $error("input stalled while output drains");

  a_accept_fills_stage1: assert property (@(posedge clk) disable iff (rst)
    (hsl_valid && hsl_ready) |=> vld[1])
    else $error("accepted item lost at stage one");

  a_output_kept: assert property (@(posedge clk) disable iff (rst)
    (rgb_valid && !rgb_ready) |=> rgb_valid)
    else $error("pending result dropped");

  a_no_full_when_ready_low: assert property (@(posedge clk) disable iff (rst)
    !hsl_ready |-> ($countones(vld) == 6))
    else $error("input stalled with a bubble in the pipeline");
`endif

endmodule

`default_nettype wire
